>>> design/oriq_pkg.sv
package oriq_pkg;

  // Fixed field widths of the request and result beats and the APB port.
  localparam int unsigned DW_BITS    = 4;
  localparam int unsigned ISSUE_BITS = 4;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_ISSUE  = 1'b1;

  // Register index taken from the word address.
  localparam logic REG_DISPATCH_WIDTH = 1'b0;

  localparam logic [DW_BITS-1:0] DISPATCH_WIDTH_RESET = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } buf_ctrl_t;

endpackage

>>> design/oldest_ready_issue_queue.sv
// Channel  Direction  Handshake                        Payload
// in       input      in_valid_i / in_ready_o          req_type, payload, src ready, issue_count
// out      output     out_valid_o / out_ready_i        accepted, issued_*, room, last
// cfg      input      APB psel/penable/pwrite, pready  dispatch_width at word 0
//
// An insert yields one beat. An issue request has the cell chain rotate the
// queue once through its occupied entries, then emits its result beats, at
// least one.
// The queue is kept compact and in age order, cell zero holding the oldest entry.
// Reset empties the queue and sets dispatch_width to one; no clearing pass.
// A stalled output holds its beat; no new request is taken until it drains.
module oldest_ready_issue_queue #(
  parameter int unsigned ENTRIES      = 16,
  parameter int unsigned MAX_ISSUE    = 8,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [PAYLOAD_BITS-1:0]             payload_i,
  input  logic                                src1_ready_i,
  input  logic                                src2_ready_i,
  input  logic [oriq_pkg::ISSUE_BITS-1:0]     issue_count_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                accepted_o,
  output logic                                issued_valid_o,
  output logic [PAYLOAD_BITS-1:0]             issued_payload_o,
  output logic [oriq_pkg::ISSUE_BITS-1:0]     issued_total_o,
  output logic                                room_for_bundle_o,
  output logic                                last_o,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [oriq_pkg::APB_AW-1:0]         paddr,
  input  logic [oriq_pkg::APB_DW-1:0]         pwdata,
  output logic [oriq_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import oriq_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > DW_BITS) ? CNT_W : DW_BITS;
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);
  localparam logic [ISSUE_BITS:0] MAX_ISSUE_C = (ISSUE_BITS + 1)'(MAX_ISSUE);

  // Configuration register.
  logic [DW_BITS-1:0] dw_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DISPATCH_WIDTH);
  assign prdata = (paddr[2] == REG_DISPATCH_WIDTH) ? APB_DW'(dw_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q <= DISPATCH_WIDTH_RESET;
    end else if (cfg_wr) begin
      dw_q <= pwdata[DW_BITS-1:0];
    end
  end

  function automatic logic room_of(logic [CNT_W-1:0] len, logic [DW_BITS-1:0] dw);
    logic [CNT_W-1:0] free_cnt;
    free_cnt = ENTRIES_C - len;
    return CMP_W'(free_cnt) >= CMP_W'(dw);
  endfunction

  // Control state.
  state_e                state_q, state_d;
  logic [CNT_W-1:0]      len_q, len_d;
  logic [CNT_W-1:0]      steps_q, steps_d;
  logic [ISSUE_BITS-1:0] want_q, want_d;
  logic [ISSUE_BITS-1:0] n_q, n_d;
  logic [ISSUE_BITS-1:0] emit_q, emit_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic                    acc_q, acc_d;
  logic                    iv_q, iv_d;
  logic [PAYLOAD_BITS-1:0] ipl_q, ipl_d;
  logic [ISSUE_BITS-1:0]   tot_q, tot_d;
  logic                    room_q, room_d;
  logic                    last_q, last_d;

  // Cell chain.
  logic [PAYLOAD_BITS-1:0] cell_payload [ENTRIES];
  logic                    cell_rdy     [ENTRIES];
  cell_ctrl_t              cell_ctrl    [ENTRIES];

  buf_ctrl_t               buf_ctrl;
  logic [PAYLOAD_BITS-1:0] buf_head;

  logic out_free, in_fire, ins_do, rot_step, rot_pick, rot_keep, emit_last;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire = in_valid_i && in_ready_o;
  assign ins_do = in_fire && (req_type_i == REQ_INSERT) && (len_q != ENTRIES_C);

  assign rot_step = (state_q == ST_ROTATE) && (steps_q != '0);
  assign rot_pick = rot_step && cell_rdy[0] && (n_q < want_q);
  assign rot_keep = rot_step && !rot_pick;
  assign emit_last = (n_q == '0) || (emit_q == n_q - 1'b1);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [PAYLOAD_BITS-1:0] up_payload;
    logic                    up_rdy;
    logic                    ld_rot;

    if (i < ENTRIES - 1) begin : g_up
      assign up_payload = cell_payload[(i + 1) % ENTRIES];
      assign up_rdy     = cell_rdy[(i + 1) % ENTRIES];
    end else begin : g_top
      assign up_payload = '0;
      assign up_rdy     = 1'b0;
    end

    assign ld_rot = rot_keep && (len_q - 1'b1 == CNT_W'(i));
    assign cell_ctrl[i].shift = rot_step;
    assign cell_ctrl[i].load  = ld_rot || (ins_do && len_q == CNT_W'(i));

    oriq_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[i]),
      .ld_payload_i (rot_step ? cell_payload[0] : payload_i),
      .ld_rdy_i     (rot_step ? cell_rdy[0] : (src1_ready_i && src2_ready_i)),
      .up_payload_i (up_payload),
      .up_rdy_i     (up_rdy),
      .payload_o    (cell_payload[i]),
      .rdy_o        (cell_rdy[i])
    );
  end

  assign buf_ctrl.push = rot_pick;
  assign buf_ctrl.pop  = (state_q == ST_EMIT) && out_free && (n_q != '0);

  oriq_pick_buf #(
    .MAX_ISSUE    (MAX_ISSUE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_pick_buf (
    .clk_i     (clk_i),
    .ctrl_i    (buf_ctrl),
    .wr_idx_i  (n_q),
    .wr_data_i (cell_payload[0]),
    .head_o    (buf_head)
  );

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    steps_d     = steps_q;
    want_d      = want_q;
    n_d         = n_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    iv_d        = iv_q;
    ipl_d       = ipl_q;
    tot_d       = tot_q;
    room_d      = room_q;
    last_d      = last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (req_type_i == REQ_INSERT) begin
            if (ins_do) begin
              len_d = len_q + 1'b1;
            end
            out_valid_d = 1'b1;
            acc_d       = ins_do;
            iv_d        = 1'b0;
            ipl_d       = '0;
            tot_d       = '0;
            room_d      = room_of(ins_do ? len_q + 1'b1 : len_q, dw_q);
            last_d      = 1'b1;
          end else begin
            if ({1'b0, issue_count_i} > MAX_ISSUE_C) begin
              want_d = ISSUE_BITS'(MAX_ISSUE);
            end else begin
              want_d = issue_count_i;
            end
            steps_d = len_q;
            n_d     = '0;
            state_d = ST_ROTATE;
          end
        end
      end
      ST_ROTATE: begin
        if (steps_q == '0) begin
          emit_d  = '0;
          state_d = ST_EMIT;
        end else begin
          steps_d = steps_q - 1'b1;
          if (rot_pick) begin
            n_d   = n_q + 1'b1;
            len_d = len_q - 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          acc_d       = 1'b0;
          iv_d        = (n_q != '0);
          ipl_d       = (n_q != '0) ? buf_head : '0;
          tot_d       = n_q;
          room_d      = room_of(len_q, dw_q);
          last_d      = emit_last;
          emit_d      = emit_q + 1'b1;
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      steps_q     <= '0;
      want_q      <= '0;
      n_q         <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      steps_q     <= steps_d;
      want_q      <= want_d;
      n_q         <= n_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    iv_q   <= iv_d;
    ipl_q  <= ipl_d;
    tot_q  <= tot_d;
    room_q <= room_d;
    last_q <= last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = acc_q;
  assign issued_valid_o    = iv_q;
  assign issued_payload_o  = ipl_q;
  assign issued_total_o    = tot_q;
  assign room_for_bundle_o = room_q;
  assign last_o            = last_q;

endmodule

>>> design/oriq_cell.sv
module oriq_cell #(
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                    clk_i,
  input  oriq_pkg::cell_ctrl_t    ctrl_i,
  input  logic [PAYLOAD_BITS-1:0] ld_payload_i,
  input  logic                    ld_rdy_i,
  input  logic [PAYLOAD_BITS-1:0] up_payload_i,
  input  logic                    up_rdy_i,
  output logic [PAYLOAD_BITS-1:0] payload_o,
  output logic                    rdy_o
);
  import oriq_pkg::*;

  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic                    rdy_q, rdy_d;

  // A load wins over the shift: during a rotation the kept head entry lands
  // in the top occupied cell while the rest move down.
  always_comb begin
    payload_d = payload_q;
    rdy_d     = rdy_q;
    if (ctrl_i.load) begin
      payload_d = ld_payload_i;
      rdy_d     = ld_rdy_i;
    end else if (ctrl_i.shift) begin
      payload_d = up_payload_i;
      rdy_d     = up_rdy_i;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    rdy_q     <= rdy_d;
  end

  assign payload_o = payload_q;
  assign rdy_o     = rdy_q;

endmodule

>>> design/oriq_pick_buf.sv
module oriq_pick_buf #(
  parameter int unsigned MAX_ISSUE    = 8,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                              clk_i,
  input  oriq_pkg::buf_ctrl_t               ctrl_i,
  input  logic [oriq_pkg::ISSUE_BITS-1:0]   wr_idx_i,
  input  logic [PAYLOAD_BITS-1:0]           wr_data_i,
  output logic [PAYLOAD_BITS-1:0]           head_o
);
  import oriq_pkg::*;

  logic [PAYLOAD_BITS-1:0] slot_q [MAX_ISSUE];

  // Picks are written in order at the pick count and drained from slot zero.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_ISSUE; j++) begin
      if (ctrl_i.push && wr_idx_i == ISSUE_BITS'(j)) begin
        slot_q[j] <= wr_data_i;
      end else if (ctrl_i.pop) begin
        if (j < MAX_ISSUE - 1) begin
          slot_q[j] <= slot_q[(j + 1) % MAX_ISSUE];
        end
      end
    end
  end

  assign head_o = slot_q[0];

endmodule

>>> tb/oldest_ready_issue_queue_tb.sv
`timescale 1ns / 100ps

module oldest_ready_issue_queue_tb;
  import oriq_pkg::*;

  localparam int unsigned ENTRIES      = 16;
  localparam int unsigned MAX_ISSUE    = 8;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam logic [APB_AW-1:0] DW_ADDR = {REG_DISPATCH_WIDTH, 2'b00};

  typedef struct packed {
    logic                    kind;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    src1;
    logic                    src2;
    logic [ISSUE_BITS-1:0]   issue_count;
  } req_t;

  typedef struct packed {
    logic                    accepted;
    logic                    issued_valid;
    logic [PAYLOAD_BITS-1:0] issued_payload;
    logic [ISSUE_BITS-1:0]   issued_total;
    logic                    room;
    logic                    last;
  } beat_t;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    ready;
  } slot_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    req_type_i = REQ_INSERT;
  logic [PAYLOAD_BITS-1:0] payload_i = '0;
  logic                    src1_ready_i = 1'b0;
  logic                    src2_ready_i = 1'b0;
  logic [ISSUE_BITS-1:0]   issue_count_i = '0;

  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    accepted_o;
  logic                    issued_valid_o;
  logic [PAYLOAD_BITS-1:0] issued_payload_o;
  logic [ISSUE_BITS-1:0]   issued_total_o;
  logic                    room_for_bundle_o;
  logic                    last_o;

  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_AW-1:0]       paddr = '0;
  logic [APB_DW-1:0]       pwdata = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  req_t   pending_reqs[$];
  beat_t  expected_beats[$];
  slot_t  age_order[$];     // Occupied slots, oldest first.
  logic [DW_BITS-1:0] dispatch_width_q = DISPATCH_WIDTH_RESET;

  int unsigned gap_pct = 10;
  int unsigned stall_pct = 10;
  int unsigned stuck_left = 6;
  int unsigned errors = 0;
  int unsigned reqs_taken = 0;
  int unsigned inserts_refused = 0;
  int unsigned beats_seen = 0;
  int unsigned issued_seen = 0;
  int unsigned settings_run = 0;

  oldest_ready_issue_queue #(
    .ENTRIES     (ENTRIES),
    .MAX_ISSUE   (MAX_ISSUE),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .payload_i        (payload_i),
    .src1_ready_i     (src1_ready_i),
    .src2_ready_i     (src2_ready_i),
    .issue_count_i    (issue_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accepted_o       (accepted_o),
    .issued_valid_o   (issued_valid_o),
    .issued_payload_o (issued_payload_o),
    .issued_total_o   (issued_total_o),
    .room_for_bundle_o(room_for_bundle_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic room_now();
    return (int'(ENTRIES) - age_order.size()) >= int'(dispatch_width_q);
  endfunction

  // Applies one request to the queue model and queues the beats it produces.
  function automatic void predict_request(req_t r);
    beat_t b;
    int unsigned want;
    int picks[$];
    logic [PAYLOAD_BITS-1:0] issued[$];
    int i;
    b = '0;
    b.last = 1'b1;
    if (r.kind == REQ_INSERT) begin
      if (age_order.size() < ENTRIES) begin
        age_order.push_back('{payload: r.payload, ready: r.src1 & r.src2});
        b.accepted = 1'b1;
      end else begin
        inserts_refused++;
      end
      b.room = room_now();
      expected_beats.push_back(b);
    end else begin
      want = (r.issue_count > MAX_ISSUE) ? MAX_ISSUE : r.issue_count;
      for (i = 0; i < age_order.size() && picks.size() < want; i++) begin
        if (age_order[i].ready) begin
          picks.push_back(i);
          issued.push_back(age_order[i].payload);
        end
      end
      for (i = picks.size() - 1; i >= 0; i--) age_order.delete(picks[i]);
      b.room = room_now();
      if (issued.size() == 0) begin
        expected_beats.push_back(b);
      end else begin
        for (i = 0; i < issued.size(); i++) begin
          b.issued_valid = 1'b1;
          b.issued_payload = issued[i];
          b.issued_total = ISSUE_BITS'(issued.size());
          b.last = (i == issued.size() - 1);
          expected_beats.push_back(b);
        end
      end
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Driver: presents pending requests, holds each one until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_request('{kind: req_type_i, payload: payload_i, src1: src1_ready_i,
                          src2: src2_ready_i, issue_count: issue_count_i});
        reqs_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
          req_t r;
          r = pending_reqs.pop_front();
          req_type_i    <= r.kind;
          payload_i     <= r.payload;
          src1_ready_i  <= r.src1;
          src2_ready_i  <= r.src2;
          issue_count_i <= r.issue_count;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result beat against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        beat_t want_beat;
        beats_seen++;
        if (issued_valid_o === 1'b1) issued_seen++;
        if (expected_beats.size() == 0) begin
          $display("%0t: beat with nothing expected, expected none, actual payload %0h",
                   $time, issued_payload_o);
          errors++;
        end else begin
          want_beat = expected_beats.pop_front();
          check_field("accepted", want_beat.accepted, accepted_o);
          check_field("issued_valid", want_beat.issued_valid, issued_valid_o);
          check_field("issued_payload", want_beat.issued_payload, issued_payload_o);
          check_field("issued_total", want_beat.issued_total, issued_total_o);
          check_field("room_for_bundle", want_beat.room, room_for_bundle_o);
          check_field("last", want_beat.last, last_o);
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid_i || expected_beats.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_dispatch_width(input logic [DW_BITS-1:0] dw);
    // Upper write bits carry noise; only the low field is kept.
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DW_ADDR;
    pwdata  <= ($urandom() & ~32'hF) | APB_DW'(dw);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    dispatch_width_q = dw;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("dispatch_width readback", dw, prdata[DW_BITS-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_run++;
  endtask

  function automatic req_t insert_req(logic [PAYLOAD_BITS-1:0] pl, logic s1, logic s2);
    return '{kind: REQ_INSERT, payload: pl, src1: s1, src2: s2, issue_count: ISSUE_BITS'($urandom)};
  endfunction

  function automatic req_t issue_req(int unsigned cnt);
    return '{kind: REQ_ISSUE, payload: PAYLOAD_BITS'($urandom), src1: 1'($urandom),
             src2: 1'($urandom), issue_count: ISSUE_BITS'(cnt)};
  endfunction

  // Mostly ready inserts and issue requests; a few entries that never become ready,
  // since those stay in the queue for the rest of the run.
  function automatic req_t random_req(int unsigned insert_pct);
    int unsigned pick;
    logic s1;
    logic s2;
    s1 = 1'b1;
    s2 = 1'b1;
    if ($urandom_range(99) < insert_pct) begin
      if (stuck_left != 0 && $urandom_range(99) < 10) begin
        pick = $urandom_range(2);
        s1 = pick[0];
        s2 = pick[1];
        stuck_left--;
      end
      return insert_req($urandom(), s1, s2);
    end
    pick = $urandom_range(99);
    if (pick < 10) return issue_req(0);
    if (pick < 25) return issue_req($urandom_range(15, 9));
    return issue_req($urandom_range(8, 1));
  endfunction

  task automatic run_phase(input logic [DW_BITS-1:0] dw, input int unsigned n,
                           input int unsigned insert_pct, input int unsigned idle_pct);
    int unsigned k;
    wait_idle();
    set_dispatch_width(dw);
    gap_pct = idle_pct;
    stall_pct = idle_pct;
    k = 0;
    while (k < n) begin
      // Now and then a run of inserts pushes the queue toward full.
      if ($urandom_range(99) < 4) begin
        repeat (12) pending_reqs.push_back(insert_req($urandom(), 1'b1, 1'b1));
        k += 12;
      end else begin
        pending_reqs.push_back(random_req(insert_pct));
        k++;
      end
    end
    wait_idle();
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill the queue with two never-ready entries, overflow it, then
    // issue with saturating, zero and empty selections.
    set_dispatch_width(4'd15);
    for (i = 0; i < ENTRIES; i++) begin
      if (i == 4) pending_reqs.push_back(insert_req($urandom(), 1'b1, 1'b0));
      else if (i == 9) pending_reqs.push_back(insert_req($urandom(), 1'b0, 1'b1));
      else if (i == 0) pending_reqs.push_back(insert_req('0, 1'b1, 1'b1));
      else if (i == 1) pending_reqs.push_back(insert_req('1, 1'b1, 1'b1));
      else pending_reqs.push_back(insert_req($urandom(), 1'b1, 1'b1));
    end
    stuck_left -= 2;
    pending_reqs.push_back(insert_req($urandom(), 1'b1, 1'b1));
    pending_reqs.push_back(issue_req(15));
    pending_reqs.push_back(issue_req(0));
    pending_reqs.push_back(insert_req($urandom(), 1'b1, 1'b1));
    pending_reqs.push_back(issue_req(9));
    pending_reqs.push_back(issue_req(5));

    run_phase(4'd0, 64, 75, 10);
    run_phase(4'd8, 64, 80, 10);
    run_phase(4'd1, 64, 70, 0);
    run_phase(DW_BITS'($urandom_range(14, 2)), 64, 85, 10);
    run_phase(4'd4, 64, 65, 10);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d requests over %0d dispatch_width settings, %0d refused on full.",
             reqs_taken, settings_run, inserts_refused);
    $display("Checked %0d result beats, %0d of them issued instructions.",
             beats_seen, issued_seen);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/oriq_pkg.sv
design/oriq_cell.sv
design/oriq_pick_buf.sv
design/oldest_ready_issue_queue.sv
tb/oldest_ready_issue_queue_tb.sv
